// ----- sv/rre_pkg.sv -----
// ----------------------------------------------------------------------------
// Rectangle raster engine package
// Shared types and constants: command and status codes, register indexes,
// controller states and internal datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rre_pkg;

  localparam int DIM_W   = 13;
  localparam int COORD_W = 34;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

  localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BACKGROUND    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- sv/rre_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle at one address; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire                                       clk,
  input  wire                                       we,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire  [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- sv/rectangle_raster_engine_top.sv -----
// ----------------------------------------------------------------------------
// Rectangle raster engine
// Byte-per-pixel canvas in one RAM; clears, draws filled or outlined
// rectangles in fixed point and reads single pixels.
//
// Usage: items enter on in_valid/in_ready and each gives exactly one result
// on out_valid/out_ready. in_ready is high only while the controller is idle,
// which includes the time a previous result waits in the output register.
// Clear and draw scan the canvas in use one pixel per cycle through the RAM
// write port; a rejected size or an empty canvas skips the scan. A read
// steps through address, RAM read latency, capture and result load.
// When the receiver stalls, a finished item waits in the controller until
// the output register is free, and no new item is accepted meanwhile.
// Reset sets the canvas size to 512 by 512 and the background to 32 and
// empties the output; the pixel RAM is not initialized and holds undefined
// data until a clear or draw writes it. Configuration writes on cfg_we take
// effect at once; the user must make them only while the block is idle,
// which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_raster_engine_top #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 8
) (
  input  wire                clk,
  input  wire                rst_n,

  input  wire                cfg_we,
  input  wire         [1:0]  cfg_index,
  input  wire         [9:0]  cfg_data,

  input  wire                in_valid,
  output logic               in_ready,
  input  wire         [1:0]  in_cmd,
  input  wire                in_filled,
  input  wire  signed [19:0] in_rect_left,
  input  wire  signed [19:0] in_rect_top,
  input  wire         [19:0] in_rect_width,
  input  wire         [19:0] in_rect_height,
  input  wire         [7:0]  in_paint_color,
  input  wire         [8:0]  in_read_col,
  input  wire         [8:0]  in_read_row,

  output logic               out_valid,
  input  wire                out_ready,
  output logic        [1:0]  out_status,
  output logic        [7:0]  out_pixel_value
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW     = rre_pkg::DIM_W;
  localparam int CW     = rre_pkg::COORD_W;
  localparam logic signed [CW-1:0] ONE = CW'(1) <<< FRAC_BITS;

  rre_pkg::state_t state_r, state_nxt;

  logic [9:0]  canvas_width_r, canvas_height_r;
  logic [7:0]  background_r;

  logic [DW-1:0] eff_w, eff_h;
  logic          canvas_empty;

  logic [DW-1:0]     col_r, row_r;
  logic [ADDR_W-1:0] addr_r, row_base_r;
  logic              is_clear_r, fill_r;
  logic [7:0]        color_r;
  logic signed [CW-1:0] left_r, right_r, top_r, bottom_r;
  logic signed [CW-1:0] left1_r, right1_r, top1_r, bottom1_r;
  logic [1:0]        status_r;
  logic [7:0]        pix_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [7:0]        out_pixel_r;

  logic signed [CW-1:0] px, py, in_left, in_top, in_right, in_bottom;
  logic covered, near_edge, paint;
  logic last_col, last_row;
  logic accept, size_zero, read_outside;
  logic out_load;
  logic ram_we;
  logic [7:0] ram_wdata, ram_rdata;

  assign eff_w = ({3'b0, canvas_width_r} > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH)
                                                           : {3'b0, canvas_width_r};
  assign eff_h = ({3'b0, canvas_height_r} > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT)
                                                             : {3'b0, canvas_height_r};
  assign canvas_empty = (eff_w == '0) || (eff_h == '0);

  assign accept       = in_valid && in_ready;
  assign size_zero    = (in_rect_width == '0) || (in_rect_height == '0);
  assign read_outside = ({4'b0, in_read_col} >= eff_w) || ({4'b0, in_read_row} >= eff_h);

  assign in_left   = CW'(in_rect_left);
  assign in_top    = CW'(in_rect_top);
  assign in_right  = in_left + $signed(CW'(in_rect_width));
  assign in_bottom = in_top + $signed(CW'(in_rect_height));

  assign px = $signed(CW'(col_r)) <<< FRAC_BITS;
  assign py = $signed(CW'(row_r)) <<< FRAC_BITS;
  assign covered   = (px >= left_r) && (px <= right_r) && (py >= top_r) && (py <= bottom_r);
  assign near_edge = (px < left1_r) || (px > right1_r) || (py < top1_r) || (py > bottom1_r);
  assign paint     = is_clear_r || (covered && (fill_r || near_edge));

  assign last_col = (col_r == eff_w - DW'(1));
  assign last_row = (row_r == eff_h - DW'(1));
  assign out_load = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rre_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            rre_pkg::CMD_CLEAR: state_nxt = canvas_empty ? rre_pkg::ST_DONE
                                                         : rre_pkg::ST_SCAN;
            rre_pkg::CMD_DRAW:  state_nxt = (canvas_empty || size_zero) ? rre_pkg::ST_DONE
                                                                        : rre_pkg::ST_SCAN;
            rre_pkg::CMD_READ:  state_nxt = read_outside ? rre_pkg::ST_DONE
                                                         : rre_pkg::ST_RD_ADDR;
            default:            state_nxt = rre_pkg::ST_DONE;
          endcase
        end
      end
      rre_pkg::ST_SCAN: begin
        if (last_col && last_row) begin
          state_nxt = rre_pkg::ST_DONE;
        end
      end
      rre_pkg::ST_RD_ADDR: state_nxt = rre_pkg::ST_RD_DATA;
      rre_pkg::ST_RD_DATA: state_nxt = rre_pkg::ST_DONE;
      rre_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = rre_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rre_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = color_r;
    case (state_r)
      rre_pkg::ST_IDLE: in_ready = 1'b1;
      rre_pkg::ST_SCAN: ram_we   = paint;
      default: begin
        in_ready = 1'b0;
        ram_we   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= rre_pkg::ST_IDLE;
      canvas_width_r  <= 10'd512;
      canvas_height_r <= 10'd512;
      background_r    <= 8'd32;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          rre_pkg::REG_CANVAS_WIDTH:  canvas_width_r  <= cfg_data;
          rre_pkg::REG_CANVAS_HEIGHT: canvas_height_r <= cfg_data;
          rre_pkg::REG_BACKGROUND:    background_r    <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (state_r == rre_pkg::ST_DONE && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_r      <= '0;
      row_r      <= '0;
      row_base_r <= '0;
      is_clear_r <= (in_cmd == rre_pkg::CMD_CLEAR);
      fill_r     <= in_filled;
      color_r    <= (in_cmd == rre_pkg::CMD_CLEAR) ? background_r : in_paint_color;
      left_r     <= in_left;
      right_r    <= in_right;
      top_r      <= in_top;
      bottom_r   <= in_bottom;
      left1_r    <= in_left + ONE;
      right1_r   <= in_right - ONE;
      top1_r     <= in_top + ONE;
      bottom1_r  <= in_bottom - ONE;
      pix_r      <= '0;
      if (in_cmd == rre_pkg::CMD_READ) begin
        addr_r <= ADDR_W'(ADDR_W'(in_read_row) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(in_read_col);
      end else begin
        addr_r <= '0;
      end
      if (in_cmd == rre_pkg::CMD_DRAW && size_zero) begin
        status_r <= rre_pkg::STATUS_BAD_SIZE;
      end else if (in_cmd == rre_pkg::CMD_READ && read_outside) begin
        status_r <= rre_pkg::STATUS_OUTSIDE;
      end else begin
        status_r <= rre_pkg::STATUS_OK;
      end
    end else if (state_r == rre_pkg::ST_SCAN) begin
      if (last_col) begin
        col_r      <= '0;
        row_r      <= row_r + DW'(1);
        row_base_r <= row_base_r + ADDR_W'(MAX_WIDTH);
        addr_r     <= row_base_r + ADDR_W'(MAX_WIDTH);
      end else begin
        col_r  <= col_r + DW'(1);
        addr_r <= addr_r + ADDR_W'(1);
      end
    end else if (state_r == rre_pkg::ST_RD_DATA) begin
      pix_r <= ram_rdata;
    end
    if (state_r == rre_pkg::ST_DONE && out_load) begin
      out_status_r <= status_r;
      out_pixel_r  <= pix_r;
    end
  end

  rre_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .addr  (addr_r),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_pixel_value = out_pixel_r;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Rectangle raster engine testbench
// Drives clear, draw and read items through the valid/ready channels and
// compares every result with a cycle-free model of the canvas kept here.
// A directed table covers reset state, size rejection, extreme coordinates
// and canvas sizes; random phases follow under varied sender and receiver
// idling, including one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = 512;
  localparam int MAX_H = 512;
  localparam int FRAC = 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 1000000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               filled;
    logic signed [19:0] left;
    logic signed [19:0] top;
    logic [19:0]        width;
    logic [19:0]        height;
    logic [7:0]         color;
    logic [8:0]         col;
    logic [8:0]         row;
  } raster_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] pixel;
  } raster_result_t;

  typedef struct {
    bit             is_cfg;
    logic [1:0]     reg_idx;
    int unsigned    reg_val;
    raster_cmd_t    item;
    bit             typed;
    raster_result_t typed_result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [9:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_cmd;
  logic in_filled;
  logic signed [19:0] in_rect_left;
  logic signed [19:0] in_rect_top;
  logic [19:0] in_rect_width;
  logic [19:0] in_rect_height;
  logic [7:0] in_paint_color;
  logic [8:0] in_read_col;
  logic [8:0] in_read_row;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_pixel_value;

  logic [7:0] canvas_mem [0:MAX_W*MAX_H-1];
  bit touched [0:MAX_W*MAX_H-1];
  logic [9:0] canvas_cols_reg = 10'd512;
  logic [9:0] canvas_rows_reg = 10'd512;
  logic [7:0] bg_reg = 8'd32;

  raster_result_t pending_results [$];
  stim_row_t stim_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_req = 0;
  int unsigned rx_hold_left = 0;
  int unsigned stall_cycles = 0;

  always #5 clk = ~clk;

  rectangle_raster_engine_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_filled      (in_filled),
    .in_rect_left   (in_rect_left),
    .in_rect_top    (in_rect_top),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_paint_color (in_paint_color),
    .in_read_col    (in_read_col),
    .in_read_row    (in_read_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_pixel_value(out_pixel_value)
  );

  function automatic int unsigned eff_cols();
    return (canvas_cols_reg > MAX_W) ? MAX_W : canvas_cols_reg;
  endfunction

  function automatic int unsigned eff_rows();
    return (canvas_rows_reg > MAX_H) ? MAX_H : canvas_rows_reg;
  endfunction

  function automatic raster_result_t raster_predict(raster_cmd_t it);
    raster_result_t res;
    int unsigned w, h, r, c;
    longint one, l, t, rgt, bot, px, py;
    bit in_rect, near_edge;
    w = eff_cols();
    h = eff_rows();
    res = '0;
    one = longint'(1) << FRAC;
    case (it.cmd)
      rre_pkg::CMD_CLEAR: begin
        for (r = 0; r < h; r++)
          for (c = 0; c < w; c++) begin
            canvas_mem[r*MAX_W + c] = bg_reg;
            touched[r*MAX_W + c] = 1'b1;
          end
      end
      rre_pkg::CMD_DRAW: begin
        if (it.width == 0 || it.height == 0) begin
          res.status = rre_pkg::STATUS_BAD_SIZE;
        end else begin
          l = longint'($signed(it.left));
          t = longint'($signed(it.top));
          rgt = l + longint'(it.width);
          bot = t + longint'(it.height);
          for (r = 0; r < h; r++) begin
            py = longint'(r) * one;
            for (c = 0; c < w; c++) begin
              px = longint'(c) * one;
              in_rect = px >= l && px <= rgt && py >= t && py <= bot;
              near_edge = (px - l) < one || (rgt - px) < one ||
                          (py - t) < one || (bot - py) < one;
              if (in_rect && (it.filled || near_edge)) begin
                canvas_mem[r*MAX_W + c] = it.color;
                touched[r*MAX_W + c] = 1'b1;
              end
            end
          end
        end
      end
      rre_pkg::CMD_READ: begin
        if (it.col >= w || it.row >= h)
          res.status = rre_pkg::STATUS_OUTSIDE;
        else
          res.pixel = canvas_mem[it.row*MAX_W + it.col];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic raster_cmd_t bare_cmd(logic [1:0] cmd);
    raster_cmd_t it;
    it = '0;
    it.cmd = cmd;
    return it;
  endfunction

  function automatic raster_cmd_t draw_cmd(logic fill, logic [19:0] l, logic [19:0] t,
                                           logic [19:0] w, logic [19:0] h, logic [7:0] color);
    raster_cmd_t it;
    it = bare_cmd(rre_pkg::CMD_DRAW);
    it.filled = fill;
    it.left = l;
    it.top = t;
    it.width = w;
    it.height = h;
    it.color = color;
    return it;
  endfunction

  function automatic raster_cmd_t read_cmd(int unsigned col, int unsigned row);
    raster_cmd_t it;
    it = bare_cmd(rre_pkg::CMD_READ);
    it.col = col[8:0];
    it.row = row[8:0];
    return it;
  endfunction

  function automatic void add_item(raster_cmd_t it, bit typed, logic [1:0] status,
                                   logic [7:0] pixel);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = '0;
    row.reg_val = 0;
    row.item = it;
    row.typed = typed;
    row.typed_result = {status, pixel};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [1:0] idx, int unsigned val);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    row.item = '0;
    row.typed = 1'b0;
    row.typed_result = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic raster_cmd_t random_item();
    raster_cmd_t it;
    logic [127:0] rnd;
    int unsigned pick, w, h, col_hi, row_hi;
    w = eff_cols();
    h = eff_rows();
    rnd = {$urandom(), $urandom(), $urandom(), $urandom()};
    it = rnd[$bits(raster_cmd_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 10) begin
      it.cmd = rre_pkg::CMD_CLEAR;
    end else if (pick < 15) begin
      it.cmd = CMD_UNUSED;
    end else if (pick < 60) begin
      it.cmd = rre_pkg::CMD_DRAW;
      if ($urandom_range(9) != 0) begin
        it.left = 20'(int'($urandom_range(0, (w + 8) * 256)) - 1024);
        it.top = 20'(int'($urandom_range(0, (h + 8) * 256)) - 1024);
        it.width = 20'($urandom_range(0, (w + 4) * 256));
        it.height = 20'($urandom_range(0, (h + 4) * 256));
        if ($urandom_range(1) == 0) it.width[7:0] = '0;
        if ($urandom_range(1) == 0) it.height[7:0] = '0;
        if ($urandom_range(15) == 0) it.width = '0;
        if ($urandom_range(15) == 0) it.height = '0;
      end
    end else begin
      it.cmd = rre_pkg::CMD_READ;
      if ($urandom_range(9) != 0) begin
        col_hi = (w + 2 > 511) ? 511 : w + 2;
        row_hi = (h + 2 > 511) ? 511 : h + 2;
        it.col = 9'($urandom_range(0, col_hi));
        it.row = 9'($urandom_range(0, row_hi));
      end
      if (it.col < w && it.row < h && !touched[it.row*MAX_W + it.col])
        it.cmd = rre_pkg::CMD_CLEAR;
    end
    return it;
  endfunction

  task automatic send_item(input raster_cmd_t it, input bit typed,
                           input raster_result_t typed_result);
    raster_result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= it.cmd;
    in_filled <= it.filled;
    in_rect_left <= it.left;
    in_rect_top <= it.top;
    in_rect_width <= it.width;
    in_rect_height <= it.height;
    in_paint_color <= it.color;
    in_read_col <= it.col;
    in_read_row <= it.row;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = raster_predict(it);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[9:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rre_pkg::REG_CANVAS_WIDTH:  canvas_cols_reg = val[9:0];
      rre_pkg::REG_CANVAS_HEIGHT: canvas_rows_reg = val[9:0];
      rre_pkg::REG_BACKGROUND:    bg_reg = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left != 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    raster_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d pixel %0d",
                 $time, out_status, out_pixel_value);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_status);
          mismatch_count++;
        end
        if (out_pixel_value !== want.pixel) begin
          $display("%0t: pixel_value mismatch, expected %0d, actual %0d",
                   $time, want.pixel, out_pixel_value);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_ready === 1'b1) ||
        (out_valid === 1'b1 && out_ready === 1'b1)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase, n;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_cmd <= '0;
    in_filled <= 1'b0;
    in_rect_left <= '0;
    in_rect_top <= '0;
    in_rect_width <= '0;
    in_rect_height <= '0;
    in_paint_color <= '0;
    in_read_col <= '0;
    in_read_row <= '0;

    add_item(bare_cmd(rre_pkg::CMD_CLEAR), 1'b1, rre_pkg::STATUS_OK, 8'd0);
    add_item(read_cmd(0, 0), 1'b1, rre_pkg::STATUS_OK, 8'd32);
    add_item(read_cmd(511, 511), 1'b1, rre_pkg::STATUS_OK, 8'd32);
    add_item(draw_cmd(1'b1, 20'h00100, 20'h00100, 20'h00000, 20'h00100, 8'h11), 1'b1,
             rre_pkg::STATUS_BAD_SIZE, 8'd0);
    add_item(draw_cmd(1'b0, 20'h00100, 20'h00100, 20'h00100, 20'h00000, 8'h22), 1'b1,
             rre_pkg::STATUS_BAD_SIZE, 8'd0);
    add_item(bare_cmd(CMD_UNUSED), 1'b1, rre_pkg::STATUS_OK, 8'd0);
    add_cfg(rre_pkg::REG_CANVAS_WIDTH, 16);
    add_cfg(rre_pkg::REG_CANVAS_HEIGHT, 12);
    add_cfg(rre_pkg::REG_BACKGROUND, 'hA5);
    add_item(bare_cmd(rre_pkg::CMD_CLEAR), 1'b1, rre_pkg::STATUS_OK, 8'd0);
    add_item(draw_cmd(1'b1, 20'hFFF80, 20'h00180, 20'h00500, 20'h00300, 8'hFF), 1'b0,
             '0, '0);
    add_item(draw_cmd(1'b0, 20'h00200, 20'h00100, 20'h00800, 20'h00600, 8'h3C), 1'b0,
             '0, '0);
    add_item(draw_cmd(1'b1, 20'h80000, 20'h80000, 20'hFFFFF, 20'hFFFFF, 8'h00), 1'b0,
             '0, '0);
    add_item(draw_cmd(1'b0, 20'h7FFFF, 20'h7FFFF, 20'h00001, 20'h00001, 8'hC3), 1'b0,
             '0, '0);
    add_item(draw_cmd(1'b0, 20'h00180, 20'h00080, 20'h00A40, 20'h00780, 8'h81), 1'b0,
             '0, '0);
    add_item(read_cmd(15, 11), 1'b0, '0, '0);
    add_item(read_cmd(3, 2), 1'b0, '0, '0);
    add_item(read_cmd(16, 0), 1'b1, rre_pkg::STATUS_OUTSIDE, 8'd0);
    add_item(read_cmd(0, 12), 1'b1, rre_pkg::STATUS_OUTSIDE, 8'd0);
    add_cfg(rre_pkg::REG_CANVAS_WIDTH, 0);
    add_item(bare_cmd(rre_pkg::CMD_CLEAR), 1'b1, rre_pkg::STATUS_OK, 8'd0);
    add_item(read_cmd(0, 0), 1'b1, rre_pkg::STATUS_OUTSIDE, 8'd0);
    add_cfg(rre_pkg::REG_CANVAS_WIDTH, 1023);
    add_cfg(rre_pkg::REG_CANVAS_HEIGHT, 1);
    add_cfg(rre_pkg::REG_BACKGROUND, 'hFF);
    add_item(bare_cmd(rre_pkg::CMD_CLEAR), 1'b1, rre_pkg::STATUS_OK, 8'd0);
    add_item(read_cmd(511, 0), 1'b1, rre_pkg::STATUS_OK, 8'hFF);
    add_item(read_cmd(0, 1), 1'b1, rre_pkg::STATUS_OUTSIDE, 8'd0);
    add_item(draw_cmd(1'b1, 20'h1FF00, 20'h00000, 20'h00100, 20'h00100, 8'h5A), 1'b0,
             '0, '0);
    add_item(read_cmd(511, 0), 1'b0, '0, '0);
    add_cfg(rre_pkg::REG_CANVAS_WIDTH, 1);
    add_cfg(rre_pkg::REG_CANVAS_HEIGHT, 1023);
    add_item(bare_cmd(rre_pkg::CMD_CLEAR), 1'b1, rre_pkg::STATUS_OK, 8'd0);
    add_item(read_cmd(0, 511), 1'b1, rre_pkg::STATUS_OK, 8'hFF);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg)
        write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
      else
        send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].typed_result);
    end

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
        default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
      endcase
      write_reg(rre_pkg::REG_CANVAS_WIDTH,
                (phase == 1) ? $urandom_range(513, 1023) : $urandom_range(1, 24));
      write_reg(rre_pkg::REG_CANVAS_HEIGHT, (phase == 1) ? 1 : $urandom_range(1, 24));
      write_reg(rre_pkg::REG_BACKGROUND, $urandom_range(255));
      send_item(bare_cmd(rre_pkg::CMD_CLEAR), 1'b0, '0);
      if (phase == 0) begin
        rx_hold_req = 300;
        for (n = 0; n < 8; n++)
          send_item(read_cmd($urandom_range(0, eff_cols() - 1),
                             $urandom_range(0, eff_rows() - 1)), 1'b0, '0);
      end
      for (n = 0; n < 15; n++)
        send_item(random_item(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- rectangle_raster_engine_top.f -----
sv/rre_pkg.sv
sv/rre_ram.sv
sv/rectangle_raster_engine_top.sv
sim/testbench.sv
